/* src/bu3x_pkg.sv */
// Shared widths and constants for the 3x bilinear upscaler.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package bu3x_pkg;

    // line buffer depth in source pixels
    localparam int MAX_WIDTH  = 1024;
    // largest frame height in source rows
    localparam int MAX_HEIGHT = 1024;
    // upscale factor
    localparam int SCALE      = 3;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int EW_W    = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int EH_W    = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

    // weighted sum of four pixels, weights add up to SCALE*SCALE
    localparam int SUM_W   = $clog2(SCALE * SCALE * 255 + 1 + 4);
    // divide by nine: multiply by round(2^16/9) and shift
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

endpackage

`default_nettype wire

/* src/bilinear_upscale_3x_core.sv */
// 3x bilinear upscaler core: line buffer, 3x3 block generator, divide by nine.
// Depends on bu3x_pkg.
//
// Usage:
//   Source grey pixels enter in raster order on the pixel channel
//   (in_valid / in_stall / pixel). For each pixel at column x >= 1 and
//   row y >= 1 the block emits the nine output pixels of the 3x3 block of
//   source cell (x-1, y-1) on the result channel (out_valid / out_stall /
//   out_row / out_col / value / last_of_run), b outer and a inner;
//   last_of_run marks the ninth one.
//   Pixels of the first row or first column only fill the line buffer and
//   are taken one per cycle unless a pixel ahead of them is still waiting
//   for the generator. The generator makes one output per cycle while the
//   output side is not stalled, so in_stall is held while a block is still
//   being produced. The outputs of a block pass in order through the buffer
//   read, generator, weighted sum, divide and output register.
//   image_width (address 0) and image_height (address 4) are to be written
//   over the APB port only while the block is idle (not enforced by the block);
//   they take effect on the next pixel. Reset clears the counters and the
//   pipeline and sets the registers to 512 x 512; the line buffer holds no
//   reset and is filled by the first row. When out_stall is high the output
//   item holds and the pipeline fills, then in_stall rises; nothing is lost.
`default_nettype none

module bilinear_upscale_3x_core
    import bu3x_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // pixel channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PIX_W-1:0]   pixel,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COORD_W-1:0]      out_row,
    output logic [COORD_W-1:0]      out_col,
    output logic [PIX_W-1:0]        value,
    output logic                    last_of_run,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [1:0] LAST_STEP = 2'(SCALE - 1);

    // blend of two values with weights (3-k) and k
    function automatic logic [SUM_W-1:0] mix3(input logic [SUM_W-1:0] p,
                                              input logic [SUM_W-1:0] q,
                                              input logic [1:0]       k);
        logic [SUM_W-1:0] r;
        case (k)
            2'd0:    r = (p << 1) + p;
            2'd1:    r = (p << 1) + q;
            2'd2:    r = p + (q << 1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(512);
            height_reg <= CFG_W'(512);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // clamped frame size
    logic [EW_W-1:0] eff_width;
    logic [EH_W-1:0] eff_height;

    always_comb
    begin
        if (width_reg < CFG_W'(2))
            eff_width = EW_W'(2);
        else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH))
            eff_width = EW_W'(MAX_WIDTH);
        else
            eff_width = EW_W'(width_reg);

        if (height_reg < CFG_W'(2))
            eff_height = EH_W'(2);
        else if (EH_W'(height_reg) > EH_W'(MAX_HEIGHT))
            eff_height = EH_W'(MAX_HEIGHT);
        else
            eff_height = EH_W'(height_reg);
    end

    // handshake and stage control
    logic in_fire;
    logic s1_ready;
    logic gen_fire;
    logic gen_last;
    logic gen_free;
    logic gen_load;
    logic sum_ready;
    logic out_ready;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    logic       gen_busy_reg;
    logic [1:0] a_reg;
    logic [1:0] b_reg;

    logic sum_valid_reg;
    logic out_valid_reg;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = !s1_ready;
    assign out_ready = !out_valid_reg || !out_stall;
    assign sum_ready = !sum_valid_reg || out_ready;
    assign gen_fire  = gen_busy_reg && sum_ready;
    assign gen_last  = (a_reg == LAST_STEP) && (b_reg == LAST_STEP);
    assign gen_free  = !gen_busy_reg || (gen_fire && gen_last);
    assign gen_load  = s1_valid_reg && s1_emit_reg && gen_free;
    assign s1_ready  = !s1_valid_reg || !s1_emit_reg || gen_free;

    // column and row counters
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_fire)
        begin
            if (EW_W'(col_cnt_reg) + EW_W'(1) >= eff_width)
            begin
                col_cnt_next = '0;
                if (EH_W'(row_cnt_reg) + EH_W'(1) >= eff_height)
                    row_cnt_next = '0;
                else
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    // line buffer: read old value and write new pixel at the same column
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] above_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            above_reg             <= line_mem[col_cnt_reg];
            line_mem[col_cnt_reg] <= pixel;
        end
    end

    // left-hand pixels of the current cell
    logic [PIX_W-1:0] ul_reg;
    logic [PIX_W-1:0] ll_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
            ul_reg        <= '0;
            ll_reg        <= '0;
            gen_busy_reg  <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;

            // stage one: buffer data ready
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
                s1_emit_reg  <= (col_cnt_reg != '0) && (row_cnt_reg != '0);
            end
            if (s1_valid_reg && s1_ready)
            begin
                ul_reg <= above_reg;
                ll_reg <= s1_pixel_reg;
            end

            // block generator, one output position per cycle while the sum stage is ready
            if (gen_load)
            begin
                gen_busy_reg <= 1'b1;
                a_reg        <= '0;
                b_reg        <= '0;
            end
            else if (gen_fire)
            begin
                if (gen_last)
                begin
                    gen_busy_reg <= 1'b0;
                end
                else if (a_reg == LAST_STEP)
                begin
                    a_reg <= '0;
                    b_reg <= b_reg + 2'd1;
                end
                else
                begin
                    a_reg <= a_reg + 2'd1;
                end
            end

            if (sum_ready)
                sum_valid_reg <= gen_busy_reg;
            if (out_ready)
                out_valid_reg <= sum_valid_reg;
        end
    end

    // generator operands
    logic [PIX_W-1:0]   i00_reg, i10_reg, i01_reg, i11_reg;
    logic [COORD_W-1:0] base_row_reg, base_col_reg;
    logic [COORD_W-1:0] cell_row, cell_col;

    assign cell_row = COORD_W'(s1_row_reg - ROW_W'(1));
    assign cell_col = COORD_W'(s1_col_reg - COL_W'(1));

    // weighted sum for the current position
    logic [SUM_W-1:0] top_mix, bot_mix, cell_sum;

    assign top_mix  = mix3(SUM_W'(i00_reg), SUM_W'(i10_reg), a_reg);
    assign bot_mix  = mix3(SUM_W'(i01_reg), SUM_W'(i11_reg), a_reg);
    assign cell_sum = mix3(top_mix, bot_mix, b_reg);

    logic [SUM_W-1:0]   sum_reg;
    logic [COORD_W-1:0] sum_row_reg, sum_col_reg;
    logic               sum_last_reg;

    // divide by nine with rounding
    logic [SUM_W+RECIP_W-1:0] quot_prod;

    assign quot_prod = (SUM_W+RECIP_W)'(sum_reg + SUM_W'(4)) * (SUM_W+RECIP_W)'(RECIP_NINE);

    logic [PIX_W-1:0]   value_reg;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic               last_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_cnt_reg;
            s1_row_reg   <= row_cnt_reg;
        end
        if (gen_load)
        begin
            i00_reg      <= ul_reg;
            i10_reg      <= above_reg;
            i01_reg      <= ll_reg;
            i11_reg      <= s1_pixel_reg;
            base_row_reg <= (cell_row << 1) + cell_row;
            base_col_reg <= (cell_col << 1) + cell_col;
        end
        if (gen_fire)
        begin
            sum_reg      <= cell_sum;
            sum_row_reg  <= base_row_reg + COORD_W'(b_reg);
            sum_col_reg  <= base_col_reg + COORD_W'(a_reg);
            sum_last_reg <= gen_last;
        end
        if (out_ready && sum_valid_reg)
        begin
            value_reg <= quot_prod[RECIP_SHIFT +: PIX_W];
            row_reg   <= sum_row_reg;
            col_reg   <= sum_col_reg;
            last_reg  <= sum_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign value       = value_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

/* src/bu3x_checker.sv */
// Port-level checks for the 3x bilinear upscaler core, bound into the core module.
// Depends on bu3x_pkg and bilinear_upscale_3x_core.
`default_nettype none

module bu3x_checker
    import bu3x_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [COORD_W-1:0] out_row,
    input wire logic [COORD_W-1:0] out_col,
    input wire logic [PIX_W-1:0]   value,
    input wire logic               last_of_run,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [ADDR_W-1:0]  paddr,
    input wire logic [DATA_W-1:0]  pwdata,
    input wire logic [DATA_W-1:0]  prdata,
    input wire logic               pready
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(value) && $stable(last_of_run))
        else $error("stalled result item changed");

    // the closing item of a block is its lower right corner, never on row or column zero
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> (out_row != '0) && (out_col != '0))
        else $error("last item of a block at row or column zero");

    // within a block the next item stays on the same output row or the one below
    a_run_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) ##1 out_valid |->
            (out_row == $past(out_row)) || (out_row == $past(out_row) + COORD_W'(1)))
        else $error("block rows out of order");

    // a written width reads back on the next cycle
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
            |-> prdata == DATA_W'($past(pwdata[CFG_W-1:0])))
        else $error("width register readback mismatch");

endmodule

bind bilinear_upscale_3x_core bu3x_checker u_bu3x_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the 3x bilinear upscaler core.
// Predicts every output pixel from the source stream and the two size registers.
// Depends on bu3x_pkg and bilinear_upscale_3x_core.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bu3x_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned IDLE_CYCLES  = 8;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TARGET_ITEMS = 420;

    // register byte addresses
    typedef enum logic [ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = ADDR_W'(0),
        REG_IMAGE_HEIGHT = ADDR_W'(4)
    } reg_addr_e;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   grey;
        logic               last;
    } upscaled_px_t;

    typedef logic [PIX_W-1:0] pix_q_t[$];

    // predictor of the upscaler and store of pending output pixels
    class upscale_scoreboard;
        logic [PIX_W-1:0] line_buf [MAX_WIDTH];
        bit               written  [MAX_WIDTH];
        logic [PIX_W-1:0] upper_left;
        logic [PIX_W-1:0] lower_left;
        int unsigned      col_cnt;
        int unsigned      row_cnt;
        int unsigned      width_reg;
        int unsigned      height_reg;
        upscaled_px_t     expected_pixels[$];
        int unsigned      errors;

        function new();
            foreach (line_buf[i])
            begin
                line_buf[i] = '0;
                written[i]  = 1'b0;
            end
            upper_left = '0;
            lower_left = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = 512;
            height_reg = 512;
            errors     = 0;
        endfunction

        function int unsigned clip_width(int unsigned w);
            if (w < 2)
                return 2;
            if (w > MAX_WIDTH)
                return MAX_WIDTH;
            return w;
        endfunction

        function int unsigned clip_height(int unsigned h);
            if (h < 2)
                return 2;
            if (h > MAX_HEIGHT)
                return MAX_HEIGHT;
            return h;
        endfunction

        function void set_reg(reg_addr_e idx, int unsigned val);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = val & 32'h7FF;
            else
                height_reg = val & 32'h7FF;
        endfunction

        // a new width must not make the current row read never-filled buffer entries
        function bit width_change_safe(int unsigned w);
            int unsigned lim;
            lim = clip_width(w);
            if (row_cnt == 0)
                return 1'b1;
            for (int unsigned i = col_cnt; i < lim; i++)
                if (!written[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned pixels_left_in_frame();
            int ew;
            int eh;
            int left;
            ew   = int'(clip_width(width_reg));
            eh   = int'(clip_height(height_reg));
            left = ew * eh - (int'(row_cnt) * ew + int'(col_cnt));
            return (left < 1) ? 1 : left;
        endfunction

        // accepted source pixel: emit the 3x3 block of the cell up and to the left
        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned  x;
            int unsigned  y;
            int unsigned  above;
            int unsigned  i00;
            int unsigned  i10;
            int unsigned  i01;
            int unsigned  i11;
            int unsigned  sum;
            upscaled_px_t exp_px;
            x     = col_cnt;
            y     = row_cnt;
            above = 0;
            if (x < MAX_WIDTH)
            begin
                above       = line_buf[x];
                line_buf[x] = px;
                written[x]  = 1'b1;
            end
            if (x >= 1 && y >= 1)
            begin
                i00 = upper_left;
                i10 = above;
                i01 = lower_left;
                i11 = px;
                for (int unsigned b = 0; b < SCALE; b++)
                begin
                    for (int unsigned a = 0; a < SCALE; a++)
                    begin
                        sum = (SCALE - a) * (SCALE - b) * i00 + a * (SCALE - b) * i10
                            + (SCALE - a) * b * i01 + a * b * i11;
                        exp_px.row  = COORD_W'(SCALE * (y - 1) + b);
                        exp_px.col  = COORD_W'(SCALE * (x - 1) + a);
                        exp_px.grey = PIX_W'((sum + 4) / 9);
                        exp_px.last = (a == SCALE - 1) && (b == SCALE - 1);
                        expected_pixels.push_back(exp_px);
                    end
                end
            end
            upper_left = above;
            lower_left = px;
            if (x + 1 >= clip_width(width_reg))
            begin
                col_cnt = 0;
                row_cnt = (y + 1 >= clip_height(height_reg)) ? 0 : y + 1;
            end
            else
            begin
                col_cnt = x + 1;
            end
        endfunction

        function void check_result(upscaled_px_t got);
            upscaled_px_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output pixel row %0d col %0d value %0d",
                       got.row, got.col, got.grey);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.row !== exp_px.row)
            begin
                $error("out_row expected %0d got %0d", exp_px.row, got.row);
                errors++;
            end
            if (got.col !== exp_px.col)
            begin
                $error("out_col expected %0d got %0d", exp_px.col, got.col);
                errors++;
            end
            if (got.grey !== exp_px.grey)
            begin
                $error("value expected %0d got %0d", exp_px.grey, got.grey);
                errors++;
            end
            if (got.last !== exp_px.last)
            begin
                $error("last_of_run expected %0d got %0d", exp_px.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [PIX_W-1:0]    pixel       = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
    logic [PIX_W-1:0]    value;
    logic                last_of_run;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    upscale_scoreboard   sb = new();
    int unsigned         cycles = 0;
    int unsigned         pixels_sent = 0;
    bit                  calm = 1'b0;
    bit                  hold_request = 1'b0;

    bilinear_upscale_3x_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .last_of_run (last_of_run),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor both channels; inputs are noted before outputs are checked
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_pixel(pixel);
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{row: out_row, col: out_col, grey: value, last: last_of_run});
    end

    // receiver: random stalls, calm stretches and one long hold-off
    initial
    begin : receiver
        int unsigned r;
        int unsigned len;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end
                else if (r < 90)
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // offer one item and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px, input int unsigned gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    // drop valid, wait for every expected pixel, then let the pipeline settle
    task automatic finish_run();
        in_valid <= 1'b0;
        // the last accepted item is noted by the monitor at the edge just taken
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_run(input pix_q_t run);
        foreach (run[i])
            send_pixel(run[i], pick_gap());
        finish_run();
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input reg_addr_e idx, input int unsigned val);
        logic [DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(val & 32'h7FF))
        begin
            $error("%s readback expected %0d got %0d", idx.name(), val & 32'h7FF, rd);
            sb.errors++;
        end
    endtask

    // main sequence
    initial
    begin : main
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, extreme pixel values
        write_register(REG_IMAGE_WIDTH, 2);
        write_register(REG_IMAGE_HEIGHT, 2);
        send_run('{8'h00, 8'hFF, 8'hFF, 8'h00});
        send_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF});

        // below-range sizes act as two
        write_register(REG_IMAGE_WIDTH, 0);
        write_register(REG_IMAGE_HEIGHT, 1);
        send_run('{8'h55, 8'hAA, 8'hAA, 8'h55});

        // above-range sizes act as the maximum; first row only, no output
        write_register(REG_IMAGE_WIDTH, 2047);
        write_register(REG_IMAGE_HEIGHT, 2047);
        send_run('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20});

        // width shrinks mid-row: the column already past the bound wraps
        write_register(REG_IMAGE_WIDTH, 3);
        send_run('{8'h40, 8'h80, 8'hFE, 8'h7F});

        // height shrinks below the current row: frame ends after this row
        write_register(REG_IMAGE_HEIGHT, 2);
        send_run('{8'hFF, 8'h00, 8'hC3});

        // long receiver hold-off while the sender keeps offering items
        write_register(REG_IMAGE_WIDTH, 6);
        write_register(REG_IMAGE_HEIGHT, 6);
        hold_request = 1'b1;
        calm = 1'b1;
        for (int i = 0; i < 36; i++)
            send_pixel(random_pixel(), 0);
        calm = 1'b0;
        finish_run();

        // random phases: mostly small frames, sometimes extreme or mid-frame sizes
        while (pixels_sent < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                w = $urandom_range(2, 9);
            else
            begin
                case ($urandom_range(0, 6))
                    0: w = 0;
                    1: w = 1;
                    2: w = 1023;
                    3: w = MAX_WIDTH;
                    4: w = 2047;
                    5: w = $urandom_range(10, 40);
                    default: w = 2;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                h = $urandom_range(2, 5);
            else
            begin
                case ($urandom_range(0, 4))
                    0: h = 0;
                    1: h = 1;
                    2: h = MAX_HEIGHT;
                    3: h = 2047;
                    default: h = 2;
                endcase
            end
            if (!sb.width_change_safe(w))
                w = 2;
            case ($urandom_range(0, 3))
                0: write_register(REG_IMAGE_WIDTH, w);
                1: write_register(REG_IMAGE_HEIGHT, h);
                default:
                begin
                    write_register(REG_IMAGE_WIDTH, w);
                    write_register(REG_IMAGE_HEIGHT, h);
                end
            endcase
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1) == 0)
                n = sb.pixels_left_in_frame();
            else
                n = $urandom_range(1, 24);
            if (n > 48)
                n = 48;
            for (int unsigned i = 0; i < n; i++)
                send_pixel(random_pixel(), pick_gap());
            calm = 1'b0;
            finish_run();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
